// ----- src/mtb_pkg.sv -----
// Shared types, codes and Q4.12 arithmetic helpers for the MLP trainer.
// Holds the tanh table built at elaboration; no dependencies.
`default_nettype none
package mtb_pkg;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam int REG_W  = 13;

  localparam logic [2:0] KIND_LOAD_W = 3'd0;
  localparam logic [2:0] KIND_LOAD_X = 3'd1;
  localparam logic [2:0] KIND_LOAD_T = 3'd2;
  localparam logic [2:0] KIND_FWD    = 3'd3;
  localparam logic [2:0] KIND_TRAIN  = 3'd4;

  localparam logic REG_LR = 1'b0;
  localparam logic REG_MO = 1'b1;

  localparam logic [REG_W-1:0] LR_RESET = 13'd614;
  localparam logic [REG_W-1:0] MO_RESET = 13'd2048;

  localparam logic signed [15:0] ONE_Q = 16'sd4096;
  localparam logic [63:0] TANH_STEP_Q30 = 64'd16775851;

  typedef struct packed {
    logic [2:0]         kind;
    logic [9:0]         index;
    logic signed [15:0] value;
  } in_item_t;

  typedef struct packed {
    logic [3:0]         out_index;
    logic signed [15:0] out_value;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic [REG_W-1:0] learning_rate;
    logic [REG_W-1:0] momentum;
  } cfg_regs_t;

  // restoring long division, used only while building the table
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // tanh(k/64) in Q4.12 for k = 0..256 by an integer recurrence
  function automatic logic [257*16-1:0] build_tanh();
    logic [257*16-1:0] res;
    logic [63:0] t;
    logic [63:0] num;
    logic [63:0] den;
    res = '0;
    t = 64'd0;
    for (int k = 0; k <= 256; k++) begin
      res[k*16 +: 16] = 16'((t + 64'd131072) >> 18);
      num = (t + TANH_STEP_Q30) << 30;
      den = (64'd1 << 30) + ((t * TANH_STEP_Q30) >> 30);
      t = udiv64(num, den);
    end
    return res;
  endfunction

  localparam logic [257*16-1:0] TANH_TAB = build_tanh();

  function automatic logic signed [15:0] sat16(input logic signed [20:0] v);
    if (v > 21'sd32767) return 16'sd32767;
    if (v < -21'sd32768) return -16'sd32768;
    return 16'(v);
  endfunction

  function automatic logic signed [15:0] addq(input logic signed [15:0] a,
                                               input logic signed [15:0] b);
    return sat16(21'(a) + 21'(b));
  endfunction

  function automatic logic signed [15:0] subq(input logic signed [15:0] a,
                                               input logic signed [15:0] b);
    return sat16(21'(a) - 21'(b));
  endfunction

  // full product, floor shift by 12, saturate
  function automatic logic signed [15:0] mulq(input logic signed [16:0] a,
                                               input logic signed [15:0] b);
    logic signed [32:0] p;
    p = 33'(a) * 33'(b);
    return sat16(p[32:12]);
  endfunction

  function automatic logic signed [15:0] tanhq(input logic signed [15:0] x);
    logic signed [9:0] k;
    logic [8:0] m;
    logic signed [15:0] v;
    k = 10'(x >>> 6);
    m = k[9] ? 9'(-k) : 9'(k);
    v = TANH_TAB[m*16 +: 16];
    if (x >= 16'sd16384) return TANH_TAB[256*16 +: 16];
    if (x < -16'sd16384) return -$signed(TANH_TAB[256*16 +: 16]);
    return k[9] ? -v : v;
  endfunction

endpackage
`default_nettype wire

// ----- src/mtb_cfg.sv -----
// APB register file for learning rate and momentum.
// Depends on mtb_pkg for register types and reset values.
`default_nettype none
module mtb_cfg (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [mtb_pkg::CFG_AW-1:0] paddr,
  input  wire logic [mtb_pkg::CFG_DW-1:0] pwdata,
  output logic      [mtb_pkg::CFG_DW-1:0] prdata,
  output logic                            pready,
  output mtb_pkg::cfg_regs_t              regs
);

  mtb_pkg::cfg_regs_t regs_r, regs_nxt;

  always_comb begin
    regs_nxt = regs_r;
    if (psel && penable && pwrite) begin
      unique case (paddr[2])
        mtb_pkg::REG_LR: regs_nxt.learning_rate = pwdata[mtb_pkg::REG_W-1:0];
        mtb_pkg::REG_MO: regs_nxt.momentum = pwdata[mtb_pkg::REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.learning_rate <= mtb_pkg::LR_RESET;
      regs_r.momentum <= mtb_pkg::MO_RESET;
    end else begin
      regs_r <= regs_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == mtb_pkg::REG_MO) begin
      prdata = {{(mtb_pkg::CFG_DW-mtb_pkg::REG_W){1'b0}}, regs_r.momentum};
    end else begin
      prdata = {{(mtb_pkg::CFG_DW-mtb_pkg::REG_W){1'b0}}, regs_r.learning_rate};
    end
  end

  assign pready = 1'b1;
  assign regs = regs_r;

endmodule
`default_nettype wire

// ----- src/mlp_tanh_backprop_trainer.sv -----
// Loads write in idle. Forward, each unit, both layers: bias read, then per source
// weight read, source read, multiply, accumulate; then tanh (output units wait for
// a free result slot). Train adds error and gradient per output, a back-propagated
// sum per hidden unit and a momentum and weight update per weight. One item at a
// time. Reset is synchronous; items wait while a clearing pass zeroes the memory.
`default_nettype none
module mlp_tanh_backprop_trainer #(
  parameter int IN_SIZE  = 2,
  parameter int HID_SIZE = 3,
  parameter int OUT_SIZE = 1
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire mtb_pkg::in_item_t          in_data,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output mtb_pkg::out_item_t              out_data,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [mtb_pkg::CFG_AW-1:0] paddr,
  input  wire logic [mtb_pkg::CFG_DW-1:0] pwdata,
  output logic      [mtb_pkg::CFG_DW-1:0] prdata,
  output logic                            pready
);

  localparam int L1_BASE = (IN_SIZE + 1) * HID_SIZE;
  localparam int W_DEPTH = L1_BASE + (HID_SIZE + 1) * OUT_SIZE;
  localparam int ACT_DEPTH = IN_SIZE + HID_SIZE + OUT_SIZE;
  localparam int GRAD_DEPTH = HID_SIZE + OUT_SIZE;
  localparam int P_BASE = W_DEPTH;
  localparam int A_BASE = 2 * W_DEPTH;
  localparam int G_BASE = A_BASE + ACT_DEPTH;
  localparam int T_BASE = G_BASE + GRAD_DEPTH;
  localparam int TOT = T_BASE + OUT_SIZE;
  localparam int AW = $clog2(TOT);
  localparam int MAXN = (IN_SIZE > HID_SIZE) ?
                        ((IN_SIZE > OUT_SIZE) ? IN_SIZE : OUT_SIZE) :
                        ((HID_SIZE > OUT_SIZE) ? HID_SIZE : OUT_SIZE);
  localparam int CW = $clog2(MAXN + 1);

  typedef enum logic [29:0] {
    S_CLR    = 30'h00000001,
    S_IDLE   = 30'h00000002,
    S_F_BIAS = 30'h00000004,
    S_F_RW   = 30'h00000008,
    S_F_RA   = 30'h00000010,
    S_F_MUL  = 30'h00000020,
    S_F_ACC  = 30'h00000040,
    S_F_TANH = 30'h00000080,
    S_B_RY   = 30'h00000100,
    S_B_RT   = 30'h00000200,
    S_B_ERR  = 30'h00000400,
    S_SQ     = 30'h00000800,
    S_DER    = 30'h00001000,
    S_GM     = 30'h00002000,
    S_GW     = 30'h00004000,
    S_H_RW   = 30'h00008000,
    S_H_RG   = 30'h00010000,
    S_H_MUL  = 30'h00020000,
    S_H_ACC  = 30'h00040000,
    S_H_RA   = 30'h00080000,
    S_H_Y    = 30'h00100000,
    S_U_RS   = 30'h00200000,
    S_U_RG   = 30'h00400000,
    S_U_M1   = 30'h00800000,
    S_U_M2   = 30'h01000000,
    S_U_M3   = 30'h02000000,
    S_U_M4   = 30'h04000000,
    S_U_WP   = 30'h08000000,
    S_U_WW   = 30'h10000000,
    S_SPARE  = 30'h20000000
  } state_t;

  mtb_pkg::cfg_regs_t cfg;

  mtb_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .regs    (cfg)
  );

  logic signed [15:0] mem [TOT];
  logic signed [15:0] rdata_r;

  state_t state_r, state_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [CW-1:0] s_r, s_nxt, d_r, d_nxt;
  logic lay_r, lay_nxt, train_r, train_nxt, hid_r, hid_nxt;
  logic signed [15:0] acc_r, acc_nxt, prod_r, prod_nxt, opa_r, opa_nxt;
  logic signed [15:0] y_r, y_nxt, tmp_r, tmp_nxt;
  logic [mtb_pkg::REG_W-1:0] lr_r, lr_nxt, mo_r, mo_nxt;
  logic out_valid_r, out_valid_nxt;
  mtb_pkg::out_item_t out_r, out_nxt;

  logic we;
  logic [AW-1:0] waddr, raddr;
  logic signed [15:0] wdata;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  always_comb begin
    int n_src;
    int n_dst;
    int wbase;
    int sbase;
    int gbase;
    int dbase;
    int w;
    logic slot_free;
    logic signed [15:0] act;

    n_src = lay_r ? HID_SIZE : IN_SIZE;
    n_dst = lay_r ? OUT_SIZE : HID_SIZE;
    wbase = lay_r ? L1_BASE : 0;
    sbase = lay_r ? A_BASE + IN_SIZE : A_BASE;
    gbase = lay_r ? G_BASE + HID_SIZE : G_BASE;
    dbase = lay_r ? A_BASE + IN_SIZE + HID_SIZE : A_BASE + IN_SIZE;
    w = wbase + int'(s_r) * n_dst + int'(d_r);
    slot_free = !out_valid_r || out_ready;
    act = mtb_pkg::tanhq(acc_r);

    state_nxt = state_r;
    clr_nxt = clr_r;
    s_nxt = s_r;
    d_nxt = d_r;
    lay_nxt = lay_r;
    train_nxt = train_r;
    hid_nxt = hid_r;
    acc_nxt = acc_r;
    prod_nxt = prod_r;
    opa_nxt = opa_r;
    y_nxt = y_r;
    tmp_nxt = tmp_r;
    lr_nxt = lr_r;
    mo_nxt = mo_r;
    out_nxt = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    we = 1'b0;
    waddr = '0;
    wdata = '0;
    raddr = '0;

    unique case (state_r)
      S_CLR: begin
        we = 1'b1;
        waddr = clr_r;
        if (clr_r == AW'(TOT - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          case (in_data.kind) inside
            mtb_pkg::KIND_LOAD_W: begin
              if (int'(in_data.index) < W_DEPTH) begin
                we = 1'b1;
                waddr = AW'(in_data.index);
                wdata = in_data.value;
              end
            end
            mtb_pkg::KIND_LOAD_X: begin
              if (int'(in_data.index) < IN_SIZE) begin
                we = 1'b1;
                waddr = AW'(A_BASE + int'(in_data.index));
                wdata = in_data.value;
              end
            end
            mtb_pkg::KIND_LOAD_T: begin
              if (int'(in_data.index) < OUT_SIZE) begin
                we = 1'b1;
                waddr = AW'(T_BASE + int'(in_data.index));
                wdata = in_data.value;
              end
            end
            mtb_pkg::KIND_FWD, mtb_pkg::KIND_TRAIN: begin
              train_nxt = (in_data.kind == mtb_pkg::KIND_TRAIN);
              lr_nxt = cfg.learning_rate;
              mo_nxt = cfg.momentum;
              lay_nxt = 1'b0;
              s_nxt = '0;
              d_nxt = '0;
              state_nxt = S_F_BIAS;
            end
            default: ;
          endcase
        end
      end
      S_F_BIAS: begin
        raddr = AW'(wbase + n_src * n_dst + int'(d_r));
        state_nxt = S_F_RW;
      end
      S_F_RW: begin
        // first pass through here picks up the bias weight
        if (s_r == '0) begin
          acc_nxt = rdata_r;
        end
        raddr = AW'(w);
        state_nxt = S_F_RA;
      end
      S_F_RA: begin
        opa_nxt = rdata_r;
        raddr = AW'(sbase + int'(s_r));
        state_nxt = S_F_MUL;
      end
      S_F_MUL: begin
        prod_nxt = mtb_pkg::mulq(17'(opa_r), rdata_r);
        state_nxt = S_F_ACC;
      end
      S_F_ACC: begin
        acc_nxt = mtb_pkg::addq(acc_r, prod_r);
        if (int'(s_r) == n_src - 1) begin
          s_nxt = '0;
          state_nxt = S_F_TANH;
        end else begin
          s_nxt = s_r + 1'b1;
          state_nxt = S_F_RW;
        end
      end
      S_F_TANH: begin
        // output layer holds here until the result slot is free
        if (!lay_r || slot_free) begin
          we = 1'b1;
          waddr = AW'(dbase + int'(d_r));
          wdata = act;
          if (lay_r) begin
            out_valid_nxt = 1'b1;
            out_nxt.out_index = 4'(d_r);
            out_nxt.out_value = act;
            out_nxt.last = (int'(d_r) == OUT_SIZE - 1);
          end
          if (int'(d_r) == n_dst - 1) begin
            d_nxt = '0;
            if (!lay_r) begin
              lay_nxt = 1'b1;
              state_nxt = S_F_BIAS;
            end else if (train_r) begin
              hid_nxt = 1'b0;
              state_nxt = S_B_RY;
            end else begin
              state_nxt = S_IDLE;
            end
          end else begin
            d_nxt = d_r + 1'b1;
            state_nxt = S_F_BIAS;
          end
        end
      end
      S_B_RY: begin
        raddr = AW'(A_BASE + IN_SIZE + HID_SIZE + int'(d_r));
        state_nxt = S_B_RT;
      end
      S_B_RT: begin
        y_nxt = rdata_r;
        raddr = AW'(T_BASE + int'(d_r));
        state_nxt = S_B_ERR;
      end
      S_B_ERR: begin
        acc_nxt = mtb_pkg::subq(rdata_r, y_r);
        state_nxt = S_SQ;
      end
      S_SQ: begin
        prod_nxt = mtb_pkg::mulq(17'(y_r), y_r);
        state_nxt = S_DER;
      end
      S_DER: begin
        tmp_nxt = mtb_pkg::subq(mtb_pkg::ONE_Q, prod_r);
        state_nxt = S_GM;
      end
      S_GM: begin
        prod_nxt = mtb_pkg::mulq(17'(acc_r), tmp_r);
        state_nxt = S_GW;
      end
      S_GW: begin
        we = 1'b1;
        wdata = prod_r;
        if (!hid_r) begin
          waddr = AW'(G_BASE + HID_SIZE + int'(d_r));
          if (int'(d_r) == OUT_SIZE - 1) begin
            d_nxt = '0;
            s_nxt = '0;
            hid_nxt = 1'b1;
            acc_nxt = '0;
            state_nxt = S_H_RW;
          end else begin
            d_nxt = d_r + 1'b1;
            state_nxt = S_B_RY;
          end
        end else begin
          waddr = AW'(G_BASE + int'(s_r));
          d_nxt = '0;
          if (int'(s_r) == HID_SIZE - 1) begin
            s_nxt = '0;
            lay_nxt = 1'b0;
            state_nxt = S_U_RS;
          end else begin
            s_nxt = s_r + 1'b1;
            acc_nxt = '0;
            state_nxt = S_H_RW;
          end
        end
      end
      S_H_RW: begin
        raddr = AW'(L1_BASE + int'(s_r) * OUT_SIZE + int'(d_r));
        state_nxt = S_H_RG;
      end
      S_H_RG: begin
        opa_nxt = rdata_r;
        raddr = AW'(G_BASE + HID_SIZE + int'(d_r));
        state_nxt = S_H_MUL;
      end
      S_H_MUL: begin
        prod_nxt = mtb_pkg::mulq(17'(opa_r), rdata_r);
        state_nxt = S_H_ACC;
      end
      S_H_ACC: begin
        acc_nxt = mtb_pkg::addq(acc_r, prod_r);
        if (int'(d_r) == OUT_SIZE - 1) begin
          state_nxt = S_H_RA;
        end else begin
          d_nxt = d_r + 1'b1;
          state_nxt = S_H_RW;
        end
      end
      S_H_RA: begin
        raddr = AW'(A_BASE + IN_SIZE + int'(s_r));
        state_nxt = S_H_Y;
      end
      S_H_Y: begin
        y_nxt = rdata_r;
        state_nxt = S_SQ;
      end
      S_U_RS: begin
        raddr = AW'(sbase + int'(s_r));
        state_nxt = S_U_RG;
      end
      S_U_RG: begin
        // bias source reads as one
        y_nxt = (int'(s_r) == n_src) ? mtb_pkg::ONE_Q : rdata_r;
        raddr = AW'(gbase + int'(d_r));
        state_nxt = S_U_M1;
      end
      S_U_M1: begin
        opa_nxt = rdata_r;
        prod_nxt = mtb_pkg::mulq($signed({4'b0000, lr_r}), y_r);
        state_nxt = S_U_M2;
      end
      S_U_M2: begin
        prod_nxt = mtb_pkg::mulq(17'(prod_r), opa_r);
        raddr = AW'(P_BASE + w);
        state_nxt = S_U_M3;
      end
      S_U_M3: begin
        acc_nxt = prod_r;
        prod_nxt = mtb_pkg::mulq($signed({4'b0000, mo_r}), rdata_r);
        raddr = AW'(w);
        state_nxt = S_U_M4;
      end
      S_U_M4: begin
        tmp_nxt = mtb_pkg::addq(acc_r, prod_r);
        opa_nxt = rdata_r;
        state_nxt = S_U_WP;
      end
      S_U_WP: begin
        we = 1'b1;
        waddr = AW'(P_BASE + w);
        wdata = tmp_r;
        state_nxt = S_U_WW;
      end
      S_U_WW: begin
        we = 1'b1;
        waddr = AW'(w);
        wdata = mtb_pkg::addq(opa_r, tmp_r);
        state_nxt = S_U_RS;
        if (int'(d_r) == n_dst - 1) begin
          d_nxt = '0;
          if (int'(s_r) == n_src) begin
            s_nxt = '0;
            if (lay_r) begin
              state_nxt = S_IDLE;
            end else begin
              lay_nxt = 1'b1;
            end
          end else begin
            s_nxt = s_r + 1'b1;
          end
        end else begin
          d_nxt = d_r + 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r <= '0;
      s_r <= '0;
      d_r <= '0;
      lay_r <= 1'b0;
      train_r <= 1'b0;
      hid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      s_r <= s_nxt;
      d_r <= d_nxt;
      lay_r <= lay_nxt;
      train_r <= train_nxt;
      hid_r <= hid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    prod_r <= prod_nxt;
    opa_r <= opa_nxt;
    y_r <= y_nxt;
    tmp_r <= tmp_nxt;
    lr_r <= lr_nxt;
    mo_r <= mo_nxt;
    out_r <= out_nxt;
  end

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data = out_r;

endmodule
`default_nettype wire
